[rtl/decimal_text_to_integer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to integer block
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INTEGER_ASSERT_SVH
`define DECIMAL_TEXT_TO_INTEGER_ASSERT_SVH

// Same-cycle implication.
`define DTOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtoi: same-cycle check failed");

// Next-cycle implication.
`define DTOI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtoi: next-cycle check failed");

`endif

[rtl/dtoi_pkg.sv]
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and constants of the decimal text to integer block.
// ----------------------------------------------------------------------------
package dtoi_pkg;

    // Byte classes produced by the front end.
    localparam logic [2:0] KIND_NONE  = 3'd0;  // zero byte, not parsed
    localparam logic [2:0] KIND_SPACE = 3'd1;
    localparam logic [2:0] KIND_MINUS = 3'd2;
    localparam logic [2:0] KIND_PLUS  = 3'd3;
    localparam logic [2:0] KIND_DIGIT = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_POS = 2'd1;
    localparam logic [1:0] STATUS_NEG = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_NUL   = 8'd0;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
        logic       term;
    } t_item;

endpackage

[rtl/dtoi_front.sv]
// ----------------------------------------------------------------------------
// dtoi_front
// Classifies each incoming text byte and marks the end of a string.
// ----------------------------------------------------------------------------
module dtoi_front (
    input  logic [7:0]     i_char_in,
    input  logic           i_end_of_text,
    output dtoi_pkg::t_item o_item
);

    always_comb begin
        o_item.digit = i_char_in[3:0];
        o_item.term  = (i_char_in == dtoi_pkg::CH_NUL) || i_end_of_text;
        priority if (i_char_in == dtoi_pkg::CH_NUL) begin
            o_item.kind = dtoi_pkg::KIND_NONE;
        end else if ((i_char_in >= dtoi_pkg::CH_TAB && i_char_in <= dtoi_pkg::CH_CR)
                     || i_char_in == dtoi_pkg::CH_SPACE) begin
            o_item.kind = dtoi_pkg::KIND_SPACE;
        end else if (i_char_in == dtoi_pkg::CH_MINUS) begin
            o_item.kind = dtoi_pkg::KIND_MINUS;
        end else if (i_char_in == dtoi_pkg::CH_PLUS) begin
            o_item.kind = dtoi_pkg::KIND_PLUS;
        end else if (i_char_in >= dtoi_pkg::CH_ZERO && i_char_in <= dtoi_pkg::CH_NINE) begin
            o_item.kind = dtoi_pkg::KIND_DIGIT;
        end else begin
            o_item.kind = dtoi_pkg::KIND_OTHER;
        end
    end

endmodule

[rtl/dtoi_queue.sv]
// ----------------------------------------------------------------------------
// dtoi_queue
// Short register queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module dtoi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtoi_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dtoi_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(dtoi_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dtoi_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dtoi_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(dtoi_pkg::QUEUE_DEPTH - 1);

    dtoi_pkg::t_item r_mem [dtoi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/dtoi_back.sv]
// ----------------------------------------------------------------------------
// dtoi_back
// Parser state, multiply-by-ten accumulate with overflow check, result register.
// ----------------------------------------------------------------------------
module dtoi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  dtoi_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_number,
    output logic [1:0]      o_status
);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [67:0] POS_LIMIT = {5'd0, {63{1'b1}}};
    localparam logic [67:0] NEG_LIMIT = {5'd1, 63'd0};

    // The accumulator keeps the magnitude; the sign is applied at the output.
    logic [1:0]  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [63:0] r_mag, n_mag;
    logic [1:0]  r_ovf, n_ovf;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_number, n_number;
    logic [1:0]  r_status, n_status;

    logic        out_free;
    logic        do_add;
    logic [67:0] prod;
    logic [67:0] lim;
    logic [31:0] low_mag;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_item_valid && (!i_item.term || out_free);
    assign o_valid  = r_out_valid;
    assign o_number = r_number;
    assign o_status = r_status;

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_ready;
        n_number    = r_number;
        n_status    = r_status;
        do_add      = 1'b0;
        lim         = POS_LIMIT;
        prod        = '0;
        low_mag     = '0;

        if (o_pop) begin
            priority if (r_phase == PH_SKIP) begin
                unique case (i_item.kind)
                    dtoi_pkg::KIND_NONE,
                    dtoi_pkg::KIND_SPACE: ;
                    dtoi_pkg::KIND_MINUS: begin
                        n_neg   = 1'b1;
                        n_phase = PH_DIGITS;
                    end
                    dtoi_pkg::KIND_PLUS:  n_phase = PH_DIGITS;
                    dtoi_pkg::KIND_DIGIT: do_add = 1'b1;
                    default:              n_phase = PH_STOP;
                endcase
            end else if (r_phase == PH_DIGITS) begin
                if (i_item.kind == dtoi_pkg::KIND_DIGIT) begin
                    do_add = 1'b1;
                end else if (i_item.kind != dtoi_pkg::KIND_NONE) begin
                    n_phase = PH_STOP;
                end
            end else begin
                // Stopped: bytes are ignored until the string ends.
            end

            // mag * 10 + d, checked against the exact signed 64-bit bound.
            prod = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {64'd0, i_item.digit};
            lim  = n_neg ? NEG_LIMIT : POS_LIMIT;
            if (do_add) begin
                if (prod > lim) begin
                    n_ovf   = n_neg ? dtoi_pkg::STATUS_NEG : dtoi_pkg::STATUS_POS;
                    n_phase = PH_STOP;
                end else begin
                    n_mag   = prod[63:0];
                    n_phase = PH_DIGITS;
                end
            end

            if (i_item.term) begin
                low_mag     = n_neg ? (32'd0 - n_mag[31:0]) : n_mag[31:0];
                n_out_valid = 1'b1;
                n_status    = n_ovf;
                unique case (n_ovf)
                    dtoi_pkg::STATUS_POS: n_number = '1;
                    dtoi_pkg::STATUS_NEG: n_number = '0;
                    default:              n_number = low_mag;
                endcase
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_mag   = '0;
                n_ovf   = dtoi_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_ovf       <= dtoi_pkg::STATUS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_number <= n_number;
        r_status <= n_status;
    end

endmodule

[rtl/decimal_text_to_integer.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// A result is registered when its end byte leaves the queue, held until taken.
// Throughput: one byte per cycle; an end byte waits while a result is held.
// A two-entry queue separates the byte classifier from the parser.
// Reset: synchronous, active low; it clears the parser and the queue.
// ----------------------------------------------------------------------------
`include "decimal_text_to_integer_assert.svh"

module decimal_text_to_integer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_number,
    output logic [1:0]  o_status
);

    dtoi_pkg::t_item front_item;
    dtoi_pkg::t_item q_item;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    assign o_ready = !q_full;
    assign push    = i_valid && !q_full;

    dtoi_front u_front (
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .o_item        (front_item)
    );

    dtoi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dtoi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_number     (o_number),
        .o_status     (o_status)
    );

    `DTOI_ASSERT_IMP(a_full_has_item, i_clk, i_rst_n, !o_ready, q_valid)
    `DTOI_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, q_pop && q_item.term, !o_valid || i_ready)
    `DTOI_ASSERT_IMP(a_pos_ovf_value, i_clk, i_rst_n, o_valid && o_status == dtoi_pkg::STATUS_POS, o_number == 32'hFFFF_FFFF)
    `DTOI_ASSERT_NXT(a_result_after_term, i_clk, i_rst_n, q_pop && q_item.term, o_valid)

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes into the decimal text to integer block and checks every
// result against a predictor fed each accepted beat, or a typed row's result.
// A short table of hand-picked strings runs first, then random strings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_BEATS = 800;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 40;

    typedef enum logic [1:0] {SCAN_SKIP, SCAN_DIGITS, SCAN_STOP} t_scan_phase;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [31:0] number;
        logic [1:0]  status;
    } t_stim_row;

    // Rows with typed set carry their result; the rest use the predictor.
    localparam int DIRECTED_COUNT = 22;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{dtoi_pkg::CH_NUL,   1'b0, 1'b1, 32'd0, dtoi_pkg::STATUS_OK},  // empty string
        '{8'hFF,              1'b1, 1'b1, 32'd0, dtoi_pkg::STATUS_OK},  // high byte stops
        '{dtoi_pkg::CH_MINUS, 1'b1, 1'b1, 32'd0, dtoi_pkg::STATUS_OK},  // sign, no digits
        '{dtoi_pkg::CH_ZERO,  1'b1, 1'b1, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_SPACE, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_TAB,   1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_CR,    1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_PLUS,  1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        // A sign after a digit stops parsing.
        '{dtoi_pkg::CH_MINUS, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_NINE,  1'b1, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_MINUS, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_NINE,  1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        // A blank after a digit stops parsing.
        '{dtoi_pkg::CH_SPACE, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_NUL,   1'b1, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{8'h80,              1'b1, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_PLUS,  1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        // A second sign stops parsing.
        '{dtoi_pkg::CH_PLUS,  1'b0, 1'b0, 32'd0, dtoi_pkg::STATUS_OK},
        '{dtoi_pkg::CH_ZERO + 8'd3, 1'b1, 1'b1, 32'd0, dtoi_pkg::STATUS_OK}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_in     = dtoi_pkg::CH_NUL;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [31:0] o_number;
    logic [1:0]  o_status;

    decimal_text_to_integer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_number      (o_number),
        .o_status      (o_status)
    );

    // Predictor state for the string being parsed.
    t_scan_phase scan_phase = SCAN_SKIP;
    logic        scan_neg   = 1'b0;
    logic [63:0] scan_value = '0;
    logic [1:0]  scan_ovf   = dtoi_pkg::STATUS_OK;

    logic [31:0] pending_numbers [$];
    logic [1:0]  pending_status  [$];

    int error_count = 0;
    int beats_sent  = 0;
    int src_run     = 0;
    int sink_run    = 0;
    int stall_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c >= dtoi_pkg::CH_TAB && c <= dtoi_pkg::CH_CR) || c == dtoi_pkg::CH_SPACE;
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= dtoi_pkg::CH_ZERO && c <= dtoi_pkg::CH_NINE;
    endfunction

    // Zero-gap stretches start at random so that back-to-back beats occur too.
    function automatic int draw_gap(ref int run_left);
        if (run_left == 0 && $urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(5, 30);
        end
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic accumulate_digit(input logic [63:0] d);
        logic [63:0] mag;
        logic [63:0] lim;
        mag = scan_neg ? 64'd0 - scan_value : scan_value;
        lim = scan_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        // The magnitude is compared against the limit before it is scaled.
        if (mag > (lim - d) / 64'd10) begin
            scan_ovf   = scan_neg ? dtoi_pkg::STATUS_NEG : dtoi_pkg::STATUS_POS;
            scan_phase = SCAN_STOP;
        end else begin
            mag        = mag * 64'd10 + d;
            scan_value = scan_neg ? 64'd0 - mag : mag;
            scan_phase = SCAN_DIGITS;
        end
    endtask

    task automatic parse_beat(input logic [7:0] c, input logic last, output bit got,
                              output logic [31:0] num, output logic [1:0] st);
        got = 1'b0;
        num = '0;
        st  = dtoi_pkg::STATUS_OK;
        if (c != dtoi_pkg::CH_NUL) begin
            if (scan_phase == SCAN_SKIP) begin
                if (is_blank(c)) begin
                    // Leading blanks are skipped.
                end else if (c == dtoi_pkg::CH_MINUS) begin
                    scan_neg   = 1'b1;
                    scan_phase = SCAN_DIGITS;
                end else if (c == dtoi_pkg::CH_PLUS) begin
                    scan_phase = SCAN_DIGITS;
                end else if (is_numeral(c)) begin
                    accumulate_digit(64'(c - dtoi_pkg::CH_ZERO));
                end else begin
                    scan_phase = SCAN_STOP;
                end
            end else if (scan_phase == SCAN_DIGITS) begin
                if (is_numeral(c)) begin
                    accumulate_digit(64'(c - dtoi_pkg::CH_ZERO));
                end else begin
                    scan_phase = SCAN_STOP;
                end
            end
            if (!last) begin
                return;
            end
        end
        got = 1'b1;
        if (scan_ovf == dtoi_pkg::STATUS_POS) begin
            num = 32'hFFFF_FFFF;
            st  = dtoi_pkg::STATUS_POS;
        end else if (scan_ovf == dtoi_pkg::STATUS_NEG) begin
            num = 32'd0;
            st  = dtoi_pkg::STATUS_NEG;
        end else begin
            num = scan_value[31:0];
            st  = dtoi_pkg::STATUS_OK;
        end
        scan_phase = SCAN_SKIP;
        scan_neg   = 1'b0;
        scan_value = '0;
        scan_ovf   = dtoi_pkg::STATUS_OK;
    endtask

    task automatic send_beat(input logic [7:0] ch, input logic last, input logic typed,
                             input logic [31:0] num, input logic [1:0] st);
        int          gap;
        bit          got;
        logic [31:0] want_num;
        logic [1:0]  want_st;
        gap = draw_gap(src_run);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_char_in     <= ch;
        i_end_of_text <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        beats_sent++;
        parse_beat(ch, last, got, want_num, want_st);
        if (got) begin
            pending_numbers.push_back(typed ? num : want_num);
            pending_status.push_back(typed ? st : want_st);
        end
    endtask

    task automatic send_plain(input logic [7:0] ch, input logic last);
        send_beat(ch, last, 1'b0, 32'd0, dtoi_pkg::STATUS_OK);
    endtask

    // A number with random leading bytes from codes 9 to 14 or space, sign, length and tail.
    task automatic send_number_text();
        logic [7:0] text [$];
        string      limit_head;
        int         sel;
        int         n;
        int         idx;
        limit_head = "922337203685477580";
        repeat ($urandom_range(0, 2)) begin
            idx = $urandom_range(0, 6);
            text.push_back(idx == 6 ? dtoi_pkg::CH_SPACE : dtoi_pkg::CH_TAB + 8'(idx));
        end
        case ($urandom_range(0, 2))
            1: text.push_back(dtoi_pkg::CH_PLUS);
            2: text.push_back(dtoi_pkg::CH_MINUS);
            default: ;
        endcase
        sel = $urandom_range(0, 9);
        if (sel == 9) begin
            // Around the 64-bit limit: the last digit lands just below, on or past it.
            for (int i = 0; i < limit_head.len(); i++) begin
                text.push_back(limit_head[i]);
            end
            text.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(6, 9)));
        end else begin
            n = sel <= 5 ? $urandom_range(1, 10)
              : sel <= 7 ? $urandom_range(11, 18) : $urandom_range(19, 21);
            repeat (n) text.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 1) == 1) begin
            foreach (text[i]) send_plain(text[i], 1'b0);
            send_plain(dtoi_pkg::CH_NUL, 1'($urandom_range(0, 1)));
        end else begin
            foreach (text[i]) send_plain(text[i], i == text.size() - 1);
        end
    endtask

    // Short broken strings: random bytes mixed with digits, signs and blanks.
    task automatic send_noise_text();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0: ch = 8'($urandom_range(0, 255));
                1: ch = dtoi_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                default: begin
                    case ($urandom_range(0, 2))
                        0: ch = dtoi_pkg::CH_PLUS;
                        1: ch = dtoi_pkg::CH_MINUS;
                        default: ch = dtoi_pkg::CH_SPACE;
                    endcase
                end
            endcase
            send_plain(ch, i == n - 1 || $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic check_result(input logic [31:0] num, input logic [1:0] st);
        logic [31:0] want_num;
        logic [1:0]  want_st;
        if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("result %0d status %0d with none pending",
                                      $signed(num), st));
            return;
        end
        want_num = pending_numbers.pop_front();
        want_st  = pending_status.pop_front();
        if (num !== want_num) begin
            report_mismatch($sformatf("number %0d, wanted %0d", $signed(num),
                                      $signed(want_num)));
        end
        if (st !== want_st) begin
            report_mismatch($sformatf("status %0d, wanted %0d", st, want_st));
        end
    endtask

    // Result side: random stalls, one result beat checked per handshake.
    initial begin
        int gap;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = draw_gap(sink_run);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            check_result(o_number, o_status);
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_count <= 0;
            end else if (stall_count + 1 >= STALL_LIMIT) begin
                $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            send_beat(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].number, DIRECTED_ROWS[r].status);
        end
        while (beats_sent < DIRECTED_COUNT + RANDOM_BEATS) begin
            // Halfway through, hold the text side until every result is back.
            if (!paused && beats_sent >= DIRECTED_COUNT + RANDOM_BEATS / 2) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_numbers.size() != 0);
            end
            if ($urandom_range(0, 9) < 8) begin
                send_number_text();
            end else begin
                send_noise_text();
            end
        end
        i_valid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
